FILE: rtl/tcw_pkg.sv
// Shared constants and helpers for the text terminal character writer.
`default_nettype none

package tcw_pkg;

    localparam int SCREEN_WIDTH  = 80;
    localparam int SCREEN_HEIGHT = 25;

    localparam int ROW_W      = 5;
    localparam int COL_W      = 7;
    localparam int CHAR_W     = 8;
    localparam int COLOR_W    = 8;
    localparam int CELL_W     = 16;
    localparam int LIN_W      = 11;
    localparam int LIN_CALC_W = ROW_W + COL_W;

    localparam int CELL_COUNT = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int FILL_W     = $clog2(SCREEN_WIDTH + 1);
    localparam int CMP_W      = COL_W + 1;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_HEIGHT - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(SCREEN_WIDTH - 1);

    localparam logic [CHAR_W-1:0]  CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0]  CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0]  CH_BLANK     = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_COLOR  = 8'h0F;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Row times width plus column, kept to the low LIN_W bits.
    function automatic logic [LIN_W-1:0] linear_pos(input logic [ROW_W-1:0] row,
                                                    input logic [COL_W-1:0] col);
        logic [LIN_CALC_W-1:0] p;
        p = LIN_CALC_W'(row) * LIN_CALC_W'(SCREEN_WIDTH) + LIN_CALC_W'(col);
        return p[LIN_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/text_terminal_char_writer_top.sv
// Text terminal character writer: screen cell memory, cursor and scroll control.
`default_nettype none

// Each item is accepted in one cycle (a read item also addresses the cell
// memory then) and executed in the next, or later while the previous result
// still waits for res_ready; the registered memory data is then available
// and the result goes to the output register. The cell memory has one
// registered read port and one write port. Scrolling costs nothing extra:
// logical rows map onto physical memory rows through a rotating top-row
// offset, and every physical row keeps a fill count (cells at or beyond it
// read as blanks) and the colour it was cleared with. A backspace that wraps
// into a row whose filled part ends short of the last column blanks the gap
// one cell per cycle after the result is issued. No clearing pass follows
// reset; cmd_ready is high as soon as reset is released. The result register
// frees the input side: a new item is taken while the previous result still
// waits for res_ready.
module text_terminal_char_writer_top
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_write_en,
    input  wire logic [tcw_pkg::COLOR_W-1:0]   cfg_write_data,

    input  wire logic                          cmd_valid,
    output logic                               cmd_ready,
    input  wire logic                          command,
    input  wire logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  wire logic [tcw_pkg::ROW_W-1:0]     read_row,
    input  wire logic [tcw_pkg::COL_W-1:0]     read_col,

    output logic                               res_valid,
    input  wire logic                          res_ready,
    output logic [tcw_pkg::CELL_W-1:0]         cell_value,
    output logic [tcw_pkg::ROW_W-1:0]          cursor_row,
    output logic [tcw_pkg::COL_W-1:0]          cursor_col,
    output logic [tcw_pkg::LIN_W-1:0]          cursor_linear,
    output logic                               scrolled
);
    import tcw_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_FILL = 2'd2;

    // Map a logical row onto its physical memory row; both inputs below height.
    function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] row,
                                                  input logic [ROW_W-1:0] top);
        logic [ROW_W:0] s;
        s = {1'b0, row} + {1'b0, top};
        if (s > {1'b0, LAST_ROW})
        begin
            s = s - (ROW_W + 1)'(SCREEN_HEIGHT);
        end
        return s[ROW_W-1:0];
    endfunction

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] prow,
                                                    input logic [COL_W-1:0] col);
        logic [LIN_CALC_W-1:0] p;
        p = LIN_CALC_W'(prow) * LIN_CALC_W'(SCREEN_WIDTH) + LIN_CALC_W'(col);
        return p[ADDR_W-1:0];
    endfunction

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    logic [1:0]         state_reg, state_next;
    logic [COLOR_W-1:0] color_reg;
    logic [ROW_W-1:0]   cur_row_reg;
    logic [COL_W-1:0]   cur_col_reg;
    logic [ROW_W-1:0]   top_reg;

    // Per physical row: count of valid leading cells and the blank colour.
    logic [FILL_W-1:0]  row_fill_reg  [SCREEN_HEIGHT];
    logic [COLOR_W-1:0] row_color_reg [SCREEN_HEIGHT];

    // Held item
    logic               cmd_reg;
    logic [CHAR_W-1:0]  char_reg;
    logic [ROW_W-1:0]   rrow_reg;
    logic [COL_W-1:0]   rcol_reg;

    // Gap fill sequencer
    logic [ROW_W-1:0]   fill_row_reg;
    logic [COL_W-1:0]   fill_ptr_reg;
    logic [COL_W-1:0]   fill_end_reg;

    // Result register
    logic               res_valid_reg;
    logic [CELL_W-1:0]  cell_value_reg;
    logic [ROW_W-1:0]   cursor_row_reg;
    logic [COL_W-1:0]   cursor_col_reg;
    logic [LIN_W-1:0]   cursor_linear_reg;
    logic               scrolled_reg;

    // Cell memory
    logic [CELL_W-1:0]  screen_mem [CELL_COUNT];
    logic [CELL_W-1:0]  rd_data_reg;

    // ---------------------------------------------------------------
    // Accept and memory read address
    // ---------------------------------------------------------------
    logic               accept;
    logic               in_port_range;
    logic [ROW_W-1:0]   port_row_clip;
    logic [COL_W-1:0]   port_col_clip;
    logic [ADDR_W-1:0]  rd_addr;
    logic               rd_en;

    assign cmd_ready = (state_reg == ST_IDLE);
    assign accept    = cmd_valid && cmd_ready;

    always_comb
    begin
        in_port_range = (read_row <= LAST_ROW) && (read_col <= LAST_COL);
        port_row_clip = in_port_range ? read_row : '0;
        port_col_clip = in_port_range ? read_col : '0;
        rd_addr       = cell_addr(phys_row(port_row_clip, top_reg), port_col_clip);
        rd_en         = accept && (command == CMD_READ);
    end

    // ---------------------------------------------------------------
    // Execute: cursor motion, write target, read value
    // ---------------------------------------------------------------
    logic               exec_fire;
    logic [ROW_W-1:0]   new_row;
    logic [COL_W-1:0]   new_col;
    logic [ROW_W-1:0]   wr_row;
    logic [COL_W-1:0]   wr_col;
    logic [CHAR_W-1:0]  wr_char;
    logic               do_write;
    logic               do_scroll;
    logic               rd_in_range;
    logic [ROW_W-1:0]   rd_row_clip;
    logic [ROW_W-1:0]   phys_sel;
    logic [ROW_W-1:0]   row_idx;
    logic [FILL_W-1:0]  sel_fill;
    logic [COLOR_W-1:0] sel_color;
    logic               needs_gap;
    logic [FILL_W-1:0]  new_fill;
    logic [CELL_W-1:0]  read_value;
    logic               fill_last;

    assign exec_fire = (state_reg == ST_EXEC) && (!res_valid_reg || res_ready);
    assign fill_last = (fill_ptr_reg + COL_W'(1)) == fill_end_reg;

    always_comb
    begin
        new_row   = cur_row_reg;
        new_col   = cur_col_reg;
        wr_row    = cur_row_reg;
        wr_col    = cur_col_reg;
        wr_char   = char_reg;
        do_write  = 1'b0;
        do_scroll = 1'b0;

        if (cmd_reg == CMD_WRITE)
        begin
            priority if (char_reg == CH_NEWLINE)
            begin
                new_col = '0;
                if (cur_row_reg == LAST_ROW)
                begin
                    do_scroll = 1'b1;
                end
                else
                begin
                    new_row = cur_row_reg + ROW_W'(1);
                end
            end
            else if (char_reg == CH_BACKSPACE)
            begin
                do_write = 1'b1;
                wr_char  = CH_BLANK;
                if (cur_col_reg != '0)
                begin
                    new_col = cur_col_reg - COL_W'(1);
                end
                else if (cur_row_reg != '0)
                begin
                    new_row = cur_row_reg - ROW_W'(1);
                    new_col = LAST_COL;
                end
                wr_row = new_row;
                wr_col = new_col;
            end
            else
            begin
                do_write = 1'b1;
                if (cur_col_reg == LAST_COL)
                begin
                    new_col = '0;
                    if (cur_row_reg == LAST_ROW)
                    begin
                        do_scroll = 1'b1;
                    end
                    else
                    begin
                        new_row = cur_row_reg + ROW_W'(1);
                    end
                end
                else
                begin
                    new_col = cur_col_reg + COL_W'(1);
                end
            end
        end

        rd_in_range = (rrow_reg <= LAST_ROW) && (rcol_reg <= LAST_COL);
        rd_row_clip = rd_in_range ? rrow_reg : '0;
        phys_sel    = phys_row((cmd_reg == CMD_READ) ? rd_row_clip : wr_row, top_reg);
        row_idx     = (state_reg == ST_FILL) ? fill_row_reg : phys_sel;
        sel_fill    = row_fill_reg[row_idx];
        sel_color   = row_color_reg[row_idx];

        needs_gap = do_write && (CMP_W'(wr_col) > CMP_W'(sel_fill));
        new_fill  = ((CMP_W'(wr_col) + CMP_W'(1)) > CMP_W'(sel_fill))
                    ? FILL_W'(CMP_W'(wr_col) + CMP_W'(1)) : sel_fill;

        if (!rd_in_range)
        begin
            read_value = '0;
        end
        else if (CMP_W'(rcol_reg) < CMP_W'(sel_fill))
        begin
            read_value = rd_data_reg;
        end
        else
        begin
            read_value = {sel_color, CH_BLANK};
        end
    end

    // ---------------------------------------------------------------
    // Memory write port
    // ---------------------------------------------------------------
    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [CELL_W-1:0]  mem_wdata;

    always_comb
    begin
        if (state_reg == ST_FILL)
        begin
            mem_we    = 1'b1;
            mem_waddr = cell_addr(fill_row_reg, fill_ptr_reg);
            mem_wdata = {sel_color, CH_BLANK};
        end
        else
        begin
            mem_we    = exec_fire && do_write;
            mem_waddr = cell_addr(phys_sel, wr_col);
            mem_wdata = {color_reg, wr_char};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            screen_mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en)
        begin
            rd_data_reg <= screen_mem[rd_addr];
        end
    end

    // ---------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (exec_fire)
                begin
                    state_next = needs_gap ? ST_FILL : ST_IDLE;
                end
            end
            ST_FILL:
            begin
                if (fill_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            color_reg   <= RESET_COLOR;
            cur_row_reg <= '0;
            cur_col_reg <= '0;
            top_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                color_reg <= cfg_write_data;
            end
            if (exec_fire)
            begin
                cur_row_reg <= new_row;
                cur_col_reg <= new_col;
                if (do_scroll)
                begin
                    top_reg <= (top_reg == LAST_ROW) ? '0 : top_reg + ROW_W'(1);
                end
            end
        end
    end

    // Row bookkeeping: fill counts grow with writes, scroll recycles the top row.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SCREEN_HEIGHT; i++)
            begin
                row_fill_reg[i]  <= '0;
                row_color_reg[i] <= RESET_COLOR;
            end
        end
        else
        begin
            if (exec_fire && do_write && !needs_gap)
            begin
                row_fill_reg[phys_sel] <= new_fill;
            end
            if (exec_fire && do_scroll)
            begin
                row_fill_reg[top_reg]  <= '0;
                row_color_reg[top_reg] <= color_reg;
            end
            if ((state_reg == ST_FILL) && fill_last)
            begin
                row_fill_reg[fill_row_reg] <= FILL_W'(CMP_W'(fill_end_reg) + CMP_W'(1));
            end
        end
    end

    // Item and gap-fill registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= command;
            char_reg <= char_code;
            rrow_reg <= read_row;
            rcol_reg <= read_col;
        end
        if (exec_fire && needs_gap)
        begin
            fill_row_reg <= phys_sel;
            fill_ptr_reg <= COL_W'(sel_fill);
            fill_end_reg <= wr_col;
        end
        else if (state_reg == ST_FILL)
        begin
            fill_ptr_reg <= fill_ptr_reg + COL_W'(1);
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (exec_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            cell_value_reg    <= (cmd_reg == CMD_READ) ? read_value : '0;
            cursor_row_reg    <= new_row;
            cursor_col_reg    <= new_col;
            cursor_linear_reg <= linear_pos(new_row, new_col);
            scrolled_reg      <= do_scroll;
        end
    end

    assign res_valid     = res_valid_reg;
    assign cell_value    = cell_value_reg;
    assign cursor_row    = cursor_row_reg;
    assign cursor_col    = cursor_col_reg;
    assign cursor_linear = cursor_linear_reg;
    assign scrolled      = scrolled_reg;

endmodule

`default_nettype wire

FILE: rtl/tcw_checker.sv
// Port-level checks for the text terminal character writer, bound to its top level.
`default_nettype none

module tcw_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cmd_valid,
    input  wire logic                          cmd_ready,
    input  wire logic                          res_valid,
    input  wire logic                          res_ready,
    input  wire logic [tcw_pkg::CELL_W-1:0]    cell_value,
    input  wire logic [tcw_pkg::ROW_W-1:0]     cursor_row,
    input  wire logic [tcw_pkg::COL_W-1:0]     cursor_col,
    input  wire logic [tcw_pkg::LIN_W-1:0]     cursor_linear,
    input  wire logic                          scrolled
);
    import tcw_pkg::*;

    // A stalled result holds.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(cell_value)
            && $stable(cursor_linear) && $stable(scrolled))
        else $error("result changed while stalled");

    // The linear cursor agrees with row and column.
    a_linear: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cursor_linear == linear_pos(cursor_row, cursor_col))
        else $error("cursor_linear does not match cursor_row and cursor_col");

    // A scroll leaves the cursor at the start of the bottom row, from a write item.
    a_scroll_pos: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && scrolled |-> cursor_row == LAST_ROW && cursor_col == '0
            && cell_value == '0)
        else $error("scroll result with wrong cursor or cell value");

    // Every item passes through execution before the next is taken, so items are never taken back to back.
    a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("item taken in consecutive cycles");

endmodule

bind text_terminal_char_writer_top tcw_checker u_tcw_checker (.*);

`default_nettype wire

FILE: sim/tcw_screen_checker.sv
// Checker for the text terminal writer: mirrors the screen and cursor and compares each result.
`timescale 1ns / 1ps

module tcw_screen_checker
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic [tcw_pkg::COLOR_W-1:0]   cfg_write_data,
    input  logic                          cmd_valid,
    input  logic                          cmd_ready,
    input  logic                          command,
    input  logic [tcw_pkg::CHAR_W-1:0]    char_code,
    input  logic [tcw_pkg::ROW_W-1:0]     read_row,
    input  logic [tcw_pkg::COL_W-1:0]     read_col,
    input  logic                          res_valid,
    input  logic                          res_ready,
    input  logic [tcw_pkg::CELL_W-1:0]    cell_value,
    input  logic [tcw_pkg::ROW_W-1:0]     cursor_row,
    input  logic [tcw_pkg::COL_W-1:0]     cursor_col,
    input  logic [tcw_pkg::LIN_W-1:0]     cursor_linear,
    input  logic                          scrolled,
    output int                            mismatch_total,
    output int                            reports_waiting,
    output int                            scrolls_seen
);

    import tcw_pkg::*;

    typedef struct packed {
        logic [CELL_W-1:0] cell_val;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [LIN_W-1:0]  lin;
        logic              scr;
    } cursor_report_t;

    logic [CELL_W-1:0]  screen_mem [CELL_COUNT];
    logic [ROW_W-1:0]   pos_row;
    logic [COL_W-1:0]   pos_col;
    logic [COLOR_W-1:0] pen_color;
    cursor_report_t     pending_reports [$];
    int                 shown;

    function automatic int cell_index(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c);
        return int'(r) * SCREEN_WIDTH + int'(c);
    endfunction

    function automatic logic [CELL_W-1:0] blank_cell();
        return {pen_color, CH_BLANK};
    endfunction

    function automatic void scroll_screen();
        for (int i = 0; i < CELL_COUNT - SCREEN_WIDTH; i++)
            screen_mem[i] = screen_mem[i + SCREEN_WIDTH];
        for (int i = CELL_COUNT - SCREEN_WIDTH; i < CELL_COUNT; i++)
            screen_mem[i] = blank_cell();
    endfunction

    // Go to column 0 of the next row; report whether the screen scrolled.
    function automatic logic line_feed();
        pos_col = '0;
        if (int'(pos_row) + 1 >= SCREEN_HEIGHT)
        begin
            pos_row = LAST_ROW;
            scroll_screen();
            return 1'b1;
        end
        pos_row = pos_row + ROW_W'(1);
        return 1'b0;
    endfunction

    function automatic cursor_report_t predict_cell_and_cursor(input logic cmd,
                                                              input logic [CHAR_W-1:0] ch,
                                                              input logic [ROW_W-1:0] rr,
                                                              input logic [COL_W-1:0] rc);
        cursor_report_t rep;
        rep = '0;
        if (cmd == CMD_READ)
        begin
            if (int'(rr) < SCREEN_HEIGHT && int'(rc) < SCREEN_WIDTH)
                rep.cell_val = screen_mem[cell_index(rr, rc)];
        end
        else if (ch == CH_NEWLINE)
        begin
            rep.scr = line_feed();
        end
        else if (ch == CH_BACKSPACE)
        begin
            if (pos_col != '0)
                pos_col = pos_col - COL_W'(1);
            else if (pos_row != '0)
            begin
                pos_row = pos_row - ROW_W'(1);
                pos_col = LAST_COL;
            end
            screen_mem[cell_index(pos_row, pos_col)] = blank_cell();
        end
        else
        begin
            screen_mem[cell_index(pos_row, pos_col)] = {pen_color, ch};
            if (int'(pos_col) + 1 >= SCREEN_WIDTH)
                rep.scr = line_feed();
            else
                pos_col = pos_col + COL_W'(1);
        end
        rep.row = pos_row;
        rep.col = pos_col;
        rep.lin = LIN_W'(cell_index(pos_row, pos_col));
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cursor_report_t want;
        cursor_report_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < CELL_COUNT; i++)
                screen_mem[i] = {RESET_COLOR, CH_BLANK};
            pos_row = '0;
            pos_col = '0;
            pen_color = RESET_COLOR;
            pending_reports.delete();
            shown = 0;
            mismatch_total <= 0;
            reports_waiting <= 0;
            scrolls_seen <= 0;
        end
        else
        begin
            // Results first: a result taken at this edge belongs to an older item.
            if (res_valid && res_ready)
            begin
                got = {cell_value, cursor_row, cursor_col, cursor_linear, scrolled};
                if (pending_reports.size() == 0)
                begin
                    mismatch_total <= mismatch_total + 1;
                    if (shown < 10)
                        $display("%0t: result with nothing pending: cell %h row %0d col %0d",
                                 $realtime, cell_value, cursor_row, cursor_col);
                    shown++;
                end
                else
                begin
                    want = pending_reports.pop_front();
                    if (want.scr)
                        scrolls_seen <= scrolls_seen + 1;
                    if (got.cell_val !== want.cell_val || got.row !== want.row
                        || got.col !== want.col || got.lin !== want.lin
                        || got.scr !== want.scr)
                    begin
                        mismatch_total <= mismatch_total + 1;
                        if (shown < 10)
                            $display("%0t: mismatch exp cell %h row %0d col %0d lin %0d scr %0b",
                                     $realtime, want.cell_val, want.row, want.col, want.lin,
                                     want.scr, "; got cell %h row %0d col %0d lin %0d scr %0b",
                                     got.cell_val, got.row, got.col, got.lin, got.scr);
                        shown++;
                    end
                end
            end
            if (cfg_write_en)
                pen_color = cfg_write_data;
            if (cmd_valid && cmd_ready)
                pending_reports.push_back(
                    predict_cell_and_cursor(command, char_code, read_row, read_col));
            reports_waiting <= pending_reports.size();
        end
    end

endmodule

FILE: sim/tb_text_terminal_char_writer_top.sv
// Testbench top for the text terminal writer: stimulus, idling profiles and the verdict.
`timescale 1ns / 1ps

module tb_text_terminal_char_writer_top;

    import tcw_pkg::*;

    // Every input starts at a known value; reset is held from time zero.
    logic                clk;
    logic                rst_n          = 1'b0;
    logic                cfg_write_en   = 1'b0;
    logic [COLOR_W-1:0]  cfg_write_data = '0;
    logic                cmd_valid      = 1'b0;
    logic                cmd_ready;
    logic                command        = CMD_WRITE;
    logic [CHAR_W-1:0]   char_code      = '0;
    logic [ROW_W-1:0]    read_row       = '0;
    logic [COL_W-1:0]    read_col       = '0;
    logic                res_valid;
    logic                res_ready      = 1'b0;
    logic [CELL_W-1:0]   cell_value;
    logic [ROW_W-1:0]    cursor_row;
    logic [COL_W-1:0]    cursor_col;
    logic [LIN_W-1:0]    cursor_linear;
    logic                scrolled;

    int mismatch_total;
    int reports_waiting;
    int scrolls_seen;

    // Idle chances in percent for the sender and the receiver.
    int tx_idle_pct = 25;
    int rx_idle_pct = 46;

    // Tallies of what was sent, for the closing summary.
    int items_sent   = 0;
    int n_chars      = 0;
    int n_newlines   = 0;
    int n_backspaces = 0;
    int n_reads      = 0;

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    text_terminal_char_writer_top uut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .command        (command),
        .char_code      (char_code),
        .read_row       (read_row),
        .read_col       (read_col),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .cell_value     (cell_value),
        .cursor_row     (cursor_row),
        .cursor_col     (cursor_col),
        .cursor_linear  (cursor_linear),
        .scrolled       (scrolled)
    );

    tcw_screen_checker screen_check
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write_en    (cfg_write_en),
        .cfg_write_data  (cfg_write_data),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .command         (command),
        .char_code       (char_code),
        .read_row        (read_row),
        .read_col        (read_col),
        .res_valid       (res_valid),
        .res_ready       (res_ready),
        .cell_value      (cell_value),
        .cursor_row      (cursor_row),
        .cursor_col      (cursor_col),
        .cursor_linear   (cursor_linear),
        .scrolled        (scrolled),
        .mismatch_total  (mismatch_total),
        .reports_waiting (reports_waiting),
        .scrolls_seen    (scrolls_seen)
    );

    // Receiver side: stall at random according to the current profile.
    always @(posedge clk)
        res_ready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);

    // Present one item and hold it until the block takes it. Valid stays high
    // after acceptance so back-to-back items need no extra edge; a gap drops it.
    task automatic send_item(input logic cmd, input logic [CHAR_W-1:0] ch,
                             input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            cmd_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < tx_idle_pct);
        end
        cmd_valid <= 1'b1;
        command   <= cmd;
        char_code <= ch;
        read_row  <= rr;
        read_col  <= rc;
        do
            @(posedge clk);
        while (!cmd_ready);
        items_sent++;
        if (cmd == CMD_READ)
            n_reads++;
        else if (ch == CH_NEWLINE)
            n_newlines++;
        else if (ch == CH_BACKSPACE)
            n_backspaces++;
        else
            n_chars++;
    endtask

    // Write items carry random read coordinates so those bits toggle too.
    task automatic put_char(input logic [CHAR_W-1:0] ch);
        send_item(CMD_WRITE, ch, ROW_W'($urandom), COL_W'($urandom));
    endtask

    task automatic peek_cell(input int r, input int c);
        send_item(CMD_READ, CHAR_W'($urandom), ROW_W'(r), COL_W'(c));
    endtask

    // Any byte except the two control codes.
    function automatic logic [CHAR_W-1:0] text_byte();
        logic [CHAR_W-1:0] b;
        do
            b = CHAR_W'($urandom_range(0, 255));
        while (b == CH_NEWLINE || b == CH_BACKSPACE);
        return b;
    endfunction

    // Stop sending, wait for every pending result, then give a wrapping
    // backspace time to finish blanking its row before anything else happens.
    task automatic drain_and_settle();
        cmd_valid <= 1'b0;
        do
            @(posedge clk);
        while (reports_waiting != 0);
        repeat (SCREEN_WIDTH + 8) @(posedge clk);
    endtask

    task automatic set_text_color(input logic [COLOR_W-1:0] c);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= c;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
    endtask

    // Mostly console-like traffic: text runs, line breaks, backspace bursts and
    // read-backs. Long runs force column wrap; long backspace bursts cross rows;
    // enough line breaks keep the screen scrolling. A small share is pure noise.
    task automatic random_session(input int n_items);
        int first;
        int pick;
        int len;
        first = items_sent;
        while (items_sent - first < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(70, 170)
                                                  : $urandom_range(1, 14);
                repeat (len) put_char(text_byte());
            end
            else if (pick < 60)
            begin
                repeat ($urandom_range(1, 3)) put_char(CH_NEWLINE);
            end
            else if (pick < 70)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(75, 90)
                                                  : $urandom_range(1, 4);
                repeat (len) put_char(CH_BACKSPACE);
            end
            else if (pick < 92)
            begin
                repeat ($urandom_range(1, 4))
                begin
                    if ($urandom_range(0, 6) == 0)
                        peek_cell($urandom_range(0, 31), $urandom_range(0, 127));
                    else if ($urandom_range(0, 1) == 1)
                        peek_cell($urandom_range(SCREEN_HEIGHT - 5, SCREEN_HEIGHT - 1),
                                  $urandom_range(0, SCREEN_WIDTH - 1));
                    else
                        peek_cell($urandom_range(0, SCREEN_HEIGHT - 1),
                                  $urandom_range(0, SCREEN_WIDTH - 1));
                end
            end
            else
            begin
                send_item(1'($urandom), CHAR_W'($urandom), ROW_W'($urandom), COL_W'($urandom));
            end
        end
    endtask

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset color. Reads: fresh blanks, the last cell,
        // a row and a column just past the screen, and all-ones coordinates.
        peek_cell(0, 0);
        peek_cell(SCREEN_HEIGHT - 1, SCREEN_WIDTH - 1);
        peek_cell(SCREEN_HEIGHT, 0);
        peek_cell(0, SCREEN_WIDTH);
        peek_cell(31, 127);
        // Backspace at the origin stays put and blanks the cell.
        put_char(CH_BACKSPACE);
        // Byte extremes and a plain letter.
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'h41);
        // Newline, then backspace from column 0 back into a short row.
        put_char(CH_NEWLINE);
        put_char(CH_BACKSPACE);
        // Write at the last column: cursor wraps to the next row.
        put_char(8'h7E);
        peek_cell(0, 0);
        peek_cell(0, 1);
        peek_cell(0, 2);
        peek_cell(0, 3);
        peek_cell(0, SCREEN_WIDTH - 1);
        put_char(CH_BLANK);
        put_char(8'h80);
        put_char(CH_BACKSPACE);
        put_char(CH_NEWLINE);
        peek_cell(1, 0);
        peek_cell(1, 1);
        drain_and_settle();

        // Sender idles less than the receiver.
        set_text_color(8'h00);
        random_session(540);
        drain_and_settle();

        // Swap the idle profiles.
        set_text_color(8'hFF);
        tx_idle_pct <= 46;
        rx_idle_pct <= 25;
        random_session(540);
        drain_and_settle();

        // Full rate on both sides; pause once midway for a color change.
        set_text_color(COLOR_W'($urandom));
        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        random_session(270);
        drain_and_settle();
        set_text_color(COLOR_W'($urandom));
        random_session(270);
        drain_and_settle();

        $display("Sent %0d items: %0d characters, %0d newlines, %0d backspaces, %0d reads; %0d scrolls.",
                 items_sent, n_chars, n_newlines, n_backspaces, n_reads, scrolls_seen);
        $display("Colors: reset, 0x00, 0xFF, two random; idle sender/receiver 25/46, 46/25, none.");
        if (mismatch_total == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial
    begin
        #4_000_000;
        $display("Timeout: %0d results still pending", reports_waiting);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tcw_pkg.sv
rtl/text_terminal_char_writer_top.sv
rtl/tcw_checker.sv
sim/tcw_screen_checker.sv
sim/tb_text_terminal_char_writer_top.sv
